// ===== src/dpc_pkg.sv =====
`timescale 1ns / 1ps

package dpc_pkg;

    localparam int DEPTH_W    = 16;
    localparam int GRAY_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int BW_W       = 6;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DEPTH_W-1:0] CLAMP_RESET = 16'd30000;
    localparam logic [BW_W-1:0]    BW_RESET    = 6'd50;

    // depth / 120 = (depth >> 3) / 15; x / 15 by reciprocal 8739 / 2^17 is
    // exact for every 13-bit x
    localparam int PRE_SHIFT   = 3;
    localparam int X_W         = DEPTH_W - PRE_SHIFT;
    localparam int RECIP_W     = 14;
    localparam logic [RECIP_W-1:0] RECIP_15 = 14'd8739;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int Q_W         = PROD_W - RECIP_SHIFT;
    localparam int REM_W       = 7;
    localparam logic [REM_W-1:0] REM_HALF = 7'd60;
    localparam logic [Q_W-1:0]   GRAY_MAX = 10'd255;

    // band divider: numerator < 2^14, divisor up to 2 * 63, quotient 8 bits
    localparam int NUM_W  = 14;
    localparam int DEN_W  = 7;
    localparam int QUOT_W = 8;

    localparam int GRAY_STAGES = 3;
    localparam int DIV_STAGES  = 4;
    localparam int NUM_STAGES  = GRAY_STAGES + 1 + DIV_STAGES + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_CLAMP = 1'b0,
        REG_BAND_WIDTH  = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        BAND_RISE_G,
        BAND_FALL_B,
        BAND_RISE_R,
        BAND_FALL_G_HI,
        BAND_FALL_G_LO
    } band_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        band_t             band;
    } pix_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        pix_t             pix;
    } div_req_t;

endpackage

// ===== src/dpc_if.sv =====
`timescale 1ns / 1ps

interface dpc_in_if;
    logic                          valid;
    logic                          ready;
    logic [dpc_pkg::DEPTH_W-1:0]   depth;

    modport source (output valid, output depth, input ready);
    modport sink   (input valid, input depth, output ready);
endinterface

interface dpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dpc_pkg::GRAY_W-1:0]    gray;
    logic [dpc_pkg::CHAN_W-1:0]    red;
    logic [dpc_pkg::CHAN_W-1:0]    green;
    logic [dpc_pkg::CHAN_W-1:0]    blue;

    modport source (output valid, output gray, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input gray, input red, input green, input blue,
                    output ready);
endinterface

// ===== src/dpc_gray.sv =====
`timescale 1ns / 1ps

// Three stages: clamp, reciprocal multiply, remainder + round-half-even.
module dpc_gray
(
    input  logic                               clk,
    input  logic [dpc_pkg::GRAY_STAGES-1:0]    en,
    input  logic [dpc_pkg::DEPTH_W-1:0]        depth,
    input  logic [dpc_pkg::DEPTH_W-1:0]        clamp,
    output logic [dpc_pkg::GRAY_W-1:0]         gray
);

    logic [dpc_pkg::DEPTH_W-1:0] s0_dc_reg, s0_dc_next;
    logic [dpc_pkg::DEPTH_W-1:0] s1_dc_reg;
    logic [dpc_pkg::Q_W-1:0]     s1_q_reg, s1_q_next;
    logic [dpc_pkg::GRAY_W-1:0]  s2_gray_reg, s2_gray_next;

    logic [dpc_pkg::PROD_W-1:0]  prod;
    logic [dpc_pkg::DEPTH_W:0]   q120;
    logic [dpc_pkg::DEPTH_W-1:0] rem_full;
    logic [dpc_pkg::REM_W-1:0]   rem;
    logic                        round_up;
    logic [dpc_pkg::Q_W-1:0]     q_rnd;

    always_comb
    begin
        s0_dc_next = (depth > clamp) ? clamp : depth;
    end

    always_comb
    begin
        prod = dpc_pkg::PROD_W'(s0_dc_reg[dpc_pkg::DEPTH_W-1:dpc_pkg::PRE_SHIFT])
             * dpc_pkg::PROD_W'(dpc_pkg::RECIP_15);
        s1_q_next = prod[dpc_pkg::RECIP_SHIFT +: dpc_pkg::Q_W];
    end

    always_comb
    begin
        // q * 120 = q * 128 - q * 8
        q120 = {s1_q_reg, 7'b0} - (dpc_pkg::DEPTH_W+1)'({s1_q_reg, 3'b0});
        rem_full = s1_dc_reg - q120[dpc_pkg::DEPTH_W-1:0];
        rem = rem_full[dpc_pkg::REM_W-1:0];
        round_up = (rem > dpc_pkg::REM_HALF) || ((rem == dpc_pkg::REM_HALF) && s1_q_reg[0]);
        q_rnd = s1_q_reg + dpc_pkg::Q_W'(round_up);
        s2_gray_next = (q_rnd > dpc_pkg::GRAY_MAX) ? dpc_pkg::GRAY_MAX[dpc_pkg::GRAY_W-1:0]
                                                   : q_rnd[dpc_pkg::GRAY_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_dc_reg <= s0_dc_next;
        end
        if (en[1])
        begin
            s1_dc_reg <= s0_dc_reg;
            s1_q_reg  <= s1_q_next;
        end
        if (en[2])
        begin
            s2_gray_reg <= s2_gray_next;
        end
    end

    assign gray = s2_gray_reg;

endmodule

// ===== src/dpc_band.sv =====
`timescale 1ns / 1ps

// Picks the color band and sets up the ramp division for it.
module dpc_band
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [dpc_pkg::GRAY_W-1:0]    gray,
    input  logic [dpc_pkg::BW_W-1:0]      band_width,
    output dpc_pkg::div_req_t             req
);

    dpc_pkg::div_req_t req_reg, req_next;

    logic [dpc_pkg::BW_W-1:0]   w;
    logic [dpc_pkg::DEN_W-1:0]  w2;
    logic [dpc_pkg::GRAY_W-1:0] w3, w4;
    logic [dpc_pkg::GRAY_W:0]   w5;
    logic [dpc_pkg::GRAY_W-1:0] t, base;
    logic [dpc_pkg::GRAY_W-1:0] u8;
    logic [dpc_pkg::NUM_W-1:0]  u, wn, u255;
    dpc_pkg::band_t             band;

    always_comb
    begin
        w  = (band_width == '0) ? dpc_pkg::BW_W'(1) : band_width;
        w2 = {w, 1'b0};
        w3 = dpc_pkg::GRAY_W'(w2) + dpc_pkg::GRAY_W'(w);
        w4 = {w, 2'b0};
        // 5w can pass 255 for wide bands
        w5 = (dpc_pkg::GRAY_W+1)'(w4) + (dpc_pkg::GRAY_W+1)'(w);
        t  = ((dpc_pkg::GRAY_W+1)'(gray) > w5) ? w5[dpc_pkg::GRAY_W-1:0] : gray;

        priority if (t < dpc_pkg::GRAY_W'(w))
        begin
            band = dpc_pkg::BAND_RISE_G;
            base = '0;
        end
        else if (t < dpc_pkg::GRAY_W'(w2))
        begin
            band = dpc_pkg::BAND_FALL_B;
            base = dpc_pkg::GRAY_W'(w);
        end
        else if (t < w3)
        begin
            band = dpc_pkg::BAND_RISE_R;
            base = dpc_pkg::GRAY_W'(w2);
        end
        else if (t <= w4)
        begin
            band = dpc_pkg::BAND_FALL_G_HI;
            base = w3;
        end
        else
        begin
            band = dpc_pkg::BAND_FALL_G_LO;
            base = w4;
        end

        u8   = t - base;
        u    = dpc_pkg::NUM_W'(u8[dpc_pkg::BW_W-1:0]);
        wn   = dpc_pkg::NUM_W'(w);
        u255 = (u << 8) - u;

        req_next.pix.gray = gray;
        req_next.pix.band = band;
        unique case (band)
            dpc_pkg::BAND_RISE_G:
            begin
                req_next.num = u255;
                req_next.den = dpc_pkg::DEN_W'(w);
            end
            dpc_pkg::BAND_FALL_B:
            begin
                // ceiling division
                req_next.num = u255 + wn - dpc_pkg::NUM_W'(1);
                req_next.den = dpc_pkg::DEN_W'(w);
            end
            dpc_pkg::BAND_RISE_R:
            begin
                req_next.num = u255;
                req_next.den = dpc_pkg::DEN_W'(w);
            end
            dpc_pkg::BAND_FALL_G_HI:
            begin
                req_next.num = (u << 8) + wn;
                req_next.den = w2;
            end
            default:
            begin
                req_next.num = (u << 8) - (u << 1) + wn;
                req_next.den = w2;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_reg <= req_next;
        end
    end

    assign req = req_reg;

endmodule

// ===== src/dpc_div.sv =====
`timescale 1ns / 1ps

// Pipelined restoring divider, two quotient bits per stage, MSB first.
module dpc_div
(
    input  logic                              clk,
    input  logic [dpc_pkg::DIV_STAGES-1:0]    en,
    input  dpc_pkg::div_req_t                 req,
    output logic [dpc_pkg::QUOT_W-1:0]        quot,
    output dpc_pkg::pix_t                     pix
);

    localparam int RW = dpc_pkg::NUM_W + 1;

    logic [dpc_pkg::NUM_W-1:0]  rem_reg  [dpc_pkg::DIV_STAGES];
    logic [dpc_pkg::DEN_W-1:0]  den_reg  [dpc_pkg::DIV_STAGES];
    logic [dpc_pkg::QUOT_W-1:0] quot_reg [dpc_pkg::DIV_STAGES];
    dpc_pkg::pix_t              pix_reg  [dpc_pkg::DIV_STAGES];

    function automatic logic [dpc_pkg::NUM_W:0] div_step(
        input logic [dpc_pkg::NUM_W-1:0] rem,
        input logic [dpc_pkg::DEN_W-1:0] den,
        input int unsigned               sh
    );
        logic [RW-1:0] sub;
        sub = RW'(den) << sh;
        if ({1'b0, rem} >= sub)
            return {1'b1, rem - sub[dpc_pkg::NUM_W-1:0]};
        else
            return {1'b0, rem};
    endfunction

    genvar s;
    generate
        for (s = 0; s < dpc_pkg::DIV_STAGES; s++)
        begin : g_stage
            localparam int SH_HI = dpc_pkg::QUOT_W - 1 - 2 * s;
            localparam int SH_LO = SH_HI - 1;

            logic [dpc_pkg::NUM_W-1:0]  rem_in;
            logic [dpc_pkg::DEN_W-1:0]  den_in;
            logic [dpc_pkg::QUOT_W-1:0] quot_in;
            dpc_pkg::pix_t              pix_in;
            logic [dpc_pkg::NUM_W:0]    step_hi, step_lo;
            logic [dpc_pkg::NUM_W-1:0]  rem_next;
            logic [dpc_pkg::QUOT_W-1:0] quot_next;

            if (s == 0)
            begin : g_first
                assign rem_in  = req.num;
                assign den_in  = req.den;
                assign quot_in = '0;
                assign pix_in  = req.pix;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[s-1];
                assign den_in  = den_reg[s-1];
                assign quot_in = quot_reg[s-1];
                assign pix_in  = pix_reg[s-1];
            end

            always_comb
            begin
                step_hi   = div_step(rem_in, den_in, SH_HI);
                step_lo   = div_step(step_hi[dpc_pkg::NUM_W-1:0], den_in, SH_LO);
                rem_next  = step_lo[dpc_pkg::NUM_W-1:0];
                quot_next = quot_in;
                quot_next[SH_HI] = step_hi[dpc_pkg::NUM_W];
                quot_next[SH_LO] = step_lo[dpc_pkg::NUM_W];
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s]  <= rem_next;
                    den_reg[s]  <= den_in;
                    quot_reg[s] <= quot_next;
                    pix_reg[s]  <= pix_in;
                end
            end
        end
    endgenerate

    assign quot = quot_reg[dpc_pkg::DIV_STAGES-1];
    assign pix  = pix_reg[dpc_pkg::DIV_STAGES-1];

endmodule

// ===== src/depth_to_pseudocolor_pixel_unit.sv =====
`timescale 1ns / 1ps

// Channel     Dir   Payload                     Transfer
// depth_in    in    depth[15:0]                 valid & ready
// color_out   out   gray, red, green, blue [7:0] valid & ready
// cfg         in    cfg_idx, cfg_wdata[15:0]    cfg_we
//
// One pixel per clock sustained while color_out.ready stays high; each pixel passes
// 9 register stages: 3 gray stages, band select, 4 divider stages, output register.
// Every stage holds its own valid bit; ready propagates backward per stage, so
// bubbles are squeezed out and input is taken while a result waits at the output.
// rst_n clears valid bits and loads depth_clamp = 30000, band_width = 50.
module depth_to_pseudocolor_pixel_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    dpc_in_if.sink                            depth_in,
    dpc_out_if.source                         color_out,
    input  logic                              cfg_we,
    input  logic [dpc_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [dpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int NS   = dpc_pkg::NUM_STAGES;
    localparam int BAND = dpc_pkg::GRAY_STAGES;
    localparam int DIV0 = dpc_pkg::GRAY_STAGES + 1;

    logic [dpc_pkg::DEPTH_W-1:0] clamp_reg;
    logic [dpc_pkg::BW_W-1:0]    bw_reg;
    logic [NS-1:0]               v_reg, v_next;
    logic [NS-1:0]               en;

    logic [dpc_pkg::GRAY_W-1:0]  gray;
    dpc_pkg::div_req_t           req;
    logic [dpc_pkg::QUOT_W-1:0]  quot;
    dpc_pkg::pix_t               pix;

    logic [dpc_pkg::GRAY_W-1:0]  gray_reg;
    logic [dpc_pkg::CHAN_W-1:0]  red_reg, red_next;
    logic [dpc_pkg::CHAN_W-1:0]  green_reg, green_next;
    logic [dpc_pkg::CHAN_W-1:0]  blue_reg, blue_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg <= dpc_pkg::CLAMP_RESET;
            bw_reg    <= dpc_pkg::BW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (dpc_pkg::reg_idx_t'(cfg_idx))
                dpc_pkg::REG_DEPTH_CLAMP: clamp_reg <= cfg_wdata[dpc_pkg::DEPTH_W-1:0];
                dpc_pkg::REG_BAND_WIDTH:  bw_reg    <= cfg_wdata[dpc_pkg::BW_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or the stage after it loads too
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || color_out.ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next = v_reg;
        if (en[0])
        begin
            v_next[0] = depth_in.valid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (en[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign depth_in.ready = en[0];

    dpc_gray u_gray
    (
        .clk   (clk),
        .en    (en[dpc_pkg::GRAY_STAGES-1:0]),
        .depth (depth_in.depth),
        .clamp (clamp_reg),
        .gray  (gray)
    );

    dpc_band u_band
    (
        .clk        (clk),
        .en         (en[BAND]),
        .gray       (gray),
        .band_width (bw_reg),
        .req        (req)
    );

    dpc_div u_div
    (
        .clk  (clk),
        .en   (en[DIV0 +: dpc_pkg::DIV_STAGES]),
        .req  (req),
        .quot (quot),
        .pix  (pix)
    );

    always_comb
    begin
        unique case (pix.band)
            dpc_pkg::BAND_RISE_G:
            begin
                red_next   = '0;
                green_next = quot;
                blue_next  = '0;
            end
            dpc_pkg::BAND_FALL_B:
            begin
                red_next   = '0;
                green_next = '1;
                blue_next  = ~quot;
            end
            dpc_pkg::BAND_RISE_R:
            begin
                red_next   = quot;
                green_next = '1;
                blue_next  = '0;
            end
            dpc_pkg::BAND_FALL_G_HI:
            begin
                red_next   = '1;
                green_next = ~quot;
                blue_next  = '0;
            end
            default:
            begin
                red_next   = '1;
                green_next = 8'd127 - quot;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            gray_reg  <= pix.gray;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign color_out.valid = v_reg[NS-1];
    assign color_out.gray  = gray_reg;
    assign color_out.red   = red_reg;
    assign color_out.green = green_reg;
    assign color_out.blue  = blue_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (depth_in.valid && depth_in.ready) |=> v_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !depth_in.ready |-> ((&v_reg) && !color_out.ready))
        else $error("input stalled while the pipeline has room");

    a_red_blue_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        color_out.valid |-> (color_out.red == '0 || color_out.blue == '0))
        else $error("red and blue both nonzero");

    a_red_ramp_green_full: assert property (@(posedge clk) disable iff (!rst_n)
        color_out.valid |-> (color_out.red == '1 || color_out.red == '0 ||
                             color_out.green == '1))
        else $error("partial red outside the red ramp band");

endmodule
